/* hw/rtl/es2cal_pkg.sv */
`default_nettype none

package es2cal_pkg;

  localparam int unsigned EpochBits = 32;
  localparam int unsigned DayBits   = 16;
  localparam int unsigned SodBits   = 17;
  localparam int unsigned MinBits   = 11;
  localparam int unsigned QuadBits  = 6;
  localparam int unsigned RemBits   = 12;
  localparam int unsigned DoyBits   = 9;
  localparam int unsigned YearBits  = 12;

  // floor(x / 675) for x < 2**25 as (x * DayRecip) >> DayShift
  localparam logic [26:0] DayRecip  = 27'd101806633;
  localparam int unsigned DayShift  = 36;
  localparam logic [31:0] SecsPerDay = 32'd86400;

  // floor(x / 60) for x < 86400 and x < 1440
  localparam logic [17:0] SodRecip  = 18'd139811;
  localparam int unsigned SodShift  = 23;
  localparam logic [10:0] MinRecip  = 11'd1093;
  localparam int unsigned MinShift  = 16;

  // floor(x / 1461) for x < 2**16
  localparam logic [15:0] QuadRecip = 16'd45934;
  localparam int unsigned QuadShift = 26;
  localparam logic [15:0] DaysPerQuad = 16'd1461;

  // day counts shifted onto four-year cycles starting 1968-01-01
  localparam logic [15:0] EpochOfs     = 16'd731;
  localparam logic [15:0] EpochOfsLate = 16'd732;
  localparam logic [15:0] Mar2100      = 16'd47541;

  localparam logic [RemBits-1:0] Yr1Start = 12'd366;
  localparam logic [RemBits-1:0] Yr2Start = 12'd731;
  localparam logic [RemBits-1:0] Yr3Start = 12'd1096;
  localparam logic [DoyBits-1:0] Mar1Doy  = 9'd59;

  localparam logic [YearBits-1:0] BaseYear    = 12'd1968;
  localparam logic [YearBits-1:0] CenturyBase = 12'd2000;

  localparam logic [DoyBits-1:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

endpackage

`default_nettype wire

/* hw/rtl/epoch_seconds_to_calendar.sv */
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00 (any time-zone offset
// already applied) into second, minute, hour, Gregorian year, year less 2000 modulo 256,
// month and day of the month, valid up to 2106-02-07 06:28:15. The block is a six-stage
// pipeline built from constant reciprocal multiplies: it takes one request per clock while the
// output register is empty or taken, and returns the results in order. When the output is not taken the
// whole pipeline holds, so in_ready_o follows the output side. Nothing is kept between
// requests and reset only clears the stage valid bits.
`default_nettype none

module epoch_seconds_to_calendar
  import es2cal_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [EpochBits-1:0]  epoch_seconds_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [5:0]                 second_o,
  output logic [5:0]                 minute_o,
  output logic [4:0]                 hour_o,
  output logic [YearBits-1:0]        full_year_o,
  output logic [7:0]                 year_in_century_o,
  output logic [3:0]                 month_o,
  output logic [4:0]                 day_of_month_o
);

  localparam int unsigned Stages = 6;

  logic              adv;
  logic [Stages-1:0] vld_q, vld_d;

  assign adv        = ~vld_q[Stages-1] | out_ready_i;
  assign in_ready_o = adv;
  assign out_valid_o = vld_q[Stages-1];
  assign vld_d = {vld_q[Stages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= vld_d;
    end
  end

  // stage 1: whole days
  logic [51:0]          day_prod;
  logic [DayBits-1:0]   s1_days_d, s1_days_q;
  logic [EpochBits-1:0] s1_secs_q;

  assign day_prod  = 52'(epoch_seconds_i[31:7]) * 52'(DayRecip);
  assign s1_days_d = day_prod[DayShift +: DayBits];

  // stage 2: seconds of day, day count from 1968
  logic [31:0]        day_base;
  logic [SodBits-1:0] s2_sod_d, s2_sod_q;
  logic [DayBits-1:0] s2_dd_d, s2_dd_q;

  assign day_base = 32'(s1_days_q) * SecsPerDay;
  assign s2_sod_d = SodBits'(s1_secs_q - day_base);
  assign s2_dd_d  = s1_days_q + ((s1_days_q >= Mar2100) ? EpochOfsLate : EpochOfs);

  // stage 3: total minutes, four-year cycles
  logic [34:0]         min_prod;
  logic [31:0]         quad_prod;
  logic [MinBits-1:0]  s3_mt_d, s3_mt_q;
  logic [QuadBits-1:0] s3_quad_d, s3_quad_q;
  logic [SodBits-1:0]  s3_sod_q;
  logic [DayBits-1:0]  s3_dd_q;

  assign min_prod  = 35'(s2_sod_q) * 35'(SodRecip);
  assign s3_mt_d   = min_prod[SodShift +: MinBits];
  assign quad_prod = 32'(s2_dd_q) * 32'(QuadRecip);
  assign s3_quad_d = quad_prod[QuadShift +: QuadBits];

  // stage 4: second, hour, day within the cycle
  logic [SodBits-1:0]  min_base;
  logic [26:0]         hr_prod;
  logic [DayBits-1:0]  quad_base;
  logic [5:0]          s4_sec_d, s4_sec_q;
  logic [4:0]          s4_hr_d, s4_hr_q;
  logic [RemBits-1:0]  s4_rem_d, s4_rem_q;
  logic [MinBits-1:0]  s4_mt_q;
  logic [QuadBits-1:0] s4_quad_q;

  assign min_base  = SodBits'(s3_mt_q) * SodBits'(60);
  assign s4_sec_d  = 6'(s3_sod_q - min_base);
  assign hr_prod   = 27'(s3_mt_q) * 27'(MinRecip);
  assign s4_hr_d   = hr_prod[MinShift +: 5];
  assign quad_base = 16'(s3_quad_q) * DaysPerQuad;
  assign s4_rem_d  = RemBits'(s3_dd_q - quad_base);

  // stage 5: minute, year, day of year on a leap-year scale
  logic [MinBits-1:0] hr_base;
  logic [5:0]         s5_min_d, s5_min_q;
  logic [1:0]         yofs;
  logic [RemBits-1:0] doy_full;
  logic [DoyBits-1:0] s5_ldoy_d, s5_ldoy_q;
  logic [7:0]         s5_yq_d, s5_yq_q;
  logic [5:0]         s5_sec_q;
  logic [4:0]         s5_hr_q;

  assign hr_base  = MinBits'(s4_hr_q) * MinBits'(60);
  assign s5_min_d = 6'(s4_mt_q - hr_base);

  always_comb begin
    priority if (s4_rem_q < Yr1Start) begin
      yofs     = 2'd0;
      doy_full = s4_rem_q;
    end else if (s4_rem_q < Yr2Start) begin
      yofs     = 2'd1;
      doy_full = s4_rem_q - Yr1Start;
    end else if (s4_rem_q < Yr3Start) begin
      yofs     = 2'd2;
      doy_full = s4_rem_q - Yr2Start;
    end else begin
      yofs     = 2'd3;
      doy_full = s4_rem_q - Yr3Start;
    end
    s5_ldoy_d = doy_full[DoyBits-1:0];
    if (yofs != 2'd0 && s5_ldoy_d >= Mar1Doy) begin
      s5_ldoy_d = s5_ldoy_d + 9'd1;
    end
  end

  assign s5_yq_d = {s4_quad_q, yofs};

  // stage 6: month and day, output register
  logic [3:0]          mon;
  logic [DoyBits-1:0]  mon_base;
  logic [DoyBits-1:0]  dom_full;
  logic [YearBits-1:0] year;

  always_comb begin
    mon      = 4'd1;
    mon_base = MonthStart[0];
    for (int i = 1; i < 12; i++) begin
      if (s5_ldoy_q >= MonthStart[i]) begin
        mon      = 4'(i + 1);
        mon_base = MonthStart[i];
      end
    end
  end

  assign dom_full = s5_ldoy_q - mon_base + 9'd1;
  assign year     = BaseYear + YearBits'(s5_yq_q);

  logic [YearBits-1:0] yic_full;
  assign yic_full = year - CenturyBase;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_days_q <= s1_days_d;
      s1_secs_q <= epoch_seconds_i;

      s2_sod_q <= s2_sod_d;
      s2_dd_q  <= s2_dd_d;

      s3_mt_q   <= s3_mt_d;
      s3_quad_q <= s3_quad_d;
      s3_sod_q  <= s2_sod_q;
      s3_dd_q   <= s2_dd_q;

      s4_sec_q  <= s4_sec_d;
      s4_hr_q   <= s4_hr_d;
      s4_rem_q  <= s4_rem_d;
      s4_mt_q   <= s3_mt_q;
      s4_quad_q <= s3_quad_q;

      s5_min_q  <= s5_min_d;
      s5_ldoy_q <= s5_ldoy_d;
      s5_yq_q   <= s5_yq_d;
      s5_sec_q  <= s4_sec_q;
      s5_hr_q   <= s4_hr_q;

      second_o          <= s5_sec_q;
      minute_o          <= s5_min_q;
      hour_o            <= s5_hr_q;
      full_year_o       <= year;
      year_in_century_o <= yic_full[7:0];
      month_o           <= mon;
      day_of_month_o    <= dom_full[4:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/es2cal_chk.sv */
`default_nettype none

module es2cal_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [5:0]  second_i,
  input wire logic [5:0]  minute_i,
  input wire logic [4:0]  hour_i,
  input wire logic [11:0] full_year_i,
  input wire logic [7:0]  year_in_century_i,
  input wire logic [3:0]  month_i,
  input wire logic [4:0]  day_of_month_i
);

  logic [11:0] yic_full;
  assign yic_full = full_year_i - 12'd2000;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(full_year_i)
      && $stable(day_of_month_i) && $stable(second_i))
    else $error("result dropped or changed while stalled");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> second_i < 6'd60 && minute_i < 6'd60 && hour_i < 5'd24)
    else $error("time of day out of range");

  a_date_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> month_i >= 4'd1 && month_i <= 4'd12
      && day_of_month_i >= 5'd1 && full_year_i >= 12'd1970 && full_year_i <= 12'd2106)
    else $error("date out of range");

  a_century: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> year_in_century_i == yic_full[7:0])
    else $error("year in century disagrees with year");

  a_feb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && month_i == 4'd2 |-> day_of_month_i <= 5'd29)
    else $error("february day out of range");

endmodule

bind epoch_seconds_to_calendar es2cal_chk u_es2cal_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .second_i          (second_o),
  .minute_i          (minute_o),
  .hour_i            (hour_o),
  .full_year_i       (full_year_o),
  .year_in_century_i (year_in_century_o),
  .month_i           (month_o),
  .day_of_month_i    (day_of_month_o)
);

`default_nettype wire

/* verif/epoch_seconds_to_calendar_checker.sv */
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_checker
  import es2cal_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_ready_i,
  input  wire logic [EpochBits-1:0] epoch_seconds_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_ready_i,
  input  wire logic [5:0]           second_i,
  input  wire logic [5:0]           minute_i,
  input  wire logic [4:0]           hour_i,
  input  wire logic [YearBits-1:0]  full_year_i,
  input  wire logic [7:0]           year_in_century_i,
  input  wire logic [3:0]           month_i,
  input  wire logic [4:0]           day_of_month_i,
  output int                        mismatch_count_o,
  output int                        dates_checked_o,
  output int                        dates_pending_o
);

  typedef struct packed {
    logic [5:0]          second;
    logic [5:0]          minute;
    logic [4:0]          hour;
    logic [YearBits-1:0] full_year;
    logic [7:0]          year_in_century;
    logic [3:0]          month;
    logic [4:0]          day_of_month;
  } calendar_t;

  calendar_t expected_dates [$];
  int        mismatches = 0;
  int        checked = 0;

  function automatic bit is_leap(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic int unsigned month_days(input int unsigned mon, input int unsigned yr);
    case (mon)
      2:          return is_leap(yr) ? 29 : 28;
      4, 6, 9, 11: return 30;
      default:    return 31;
    endcase
  endfunction

  function automatic calendar_t to_calendar(input logic [EpochBits-1:0] secs);
    calendar_t   date;
    int unsigned s;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    s    = secs;
    days = s / 86400;
    yr   = 1970;
    while (days >= (is_leap(yr) ? 366 : 365)) begin
      days -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon <= 12 && days >= month_days(mon, yr)) begin
      days -= month_days(mon, yr);
      mon++;
    end
    date.second          = 6'(s % 60);
    date.minute          = 6'((s / 60) % 60);
    date.hour            = 5'((s / 3600) % 24);
    date.full_year       = YearBits'(yr);
    date.year_in_century = 8'(yr - 2000);
    date.month           = 4'(mon);
    date.day_of_month    = 5'(days + 1);
    return date;
  endfunction

  task automatic check_field(input string field, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    calendar_t want;
    if (!rst_ni) begin
      expected_dates.delete();
      dates_pending_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_dates.push_back(to_calendar(epoch_seconds_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_dates.size() == 0) begin
          $error("result with no request outstanding");
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          check_field("second", want.second, second_i);
          check_field("minute", want.minute, minute_i);
          check_field("hour", want.hour, hour_i);
          check_field("full_year", want.full_year, full_year_i);
          check_field("year_in_century", want.year_in_century, year_in_century_i);
          check_field("month", want.month, month_i);
          check_field("day_of_month", want.day_of_month, day_of_month_i);
          checked++;
        end
      end
      mismatch_count_o <= mismatches;
      dates_checked_o  <= checked;
      dates_pending_o  <= expected_dates.size();
    end
  end

endmodule

/* verif/epoch_seconds_to_calendar_tb.sv */
`timescale 1ns / 1ps

module epoch_seconds_to_calendar_tb;
  import es2cal_pkg::*;

  localparam int unsigned RandomRequests = 1600;
  localparam int unsigned CycleLimit     = 400000;
  localparam int unsigned DrainCycles    = 24;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic [EpochBits-1:0] epoch_seconds = '0;
  logic                 out_ready = 1'b0;

  logic                in_ready;
  logic                out_valid;
  logic [5:0]          second;
  logic [5:0]          minute;
  logic [4:0]          hour;
  logic [YearBits-1:0] full_year;
  logic [7:0]          year_in_century;
  logic [3:0]          month;
  logic [4:0]          day_of_month;

  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned requests_sent = 0;
  int          mismatch_count;
  int          dates_checked;
  int          dates_pending;

  logic [EpochBits-1:0] landmark_secs [$];

  epoch_seconds_to_calendar dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .epoch_seconds_i   (epoch_seconds),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .second_o          (second),
    .minute_o          (minute),
    .hour_o            (hour),
    .full_year_o       (full_year),
    .year_in_century_o (year_in_century),
    .month_o           (month),
    .day_of_month_o    (day_of_month)
  );

  epoch_seconds_to_calendar_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .epoch_seconds_i   (epoch_seconds),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .second_i          (second),
    .minute_i          (minute),
    .hour_i            (hour),
    .full_year_i       (full_year),
    .year_in_century_i (year_in_century),
    .month_i           (month),
    .day_of_month_i    (day_of_month),
    .mismatch_count_o  (mismatch_count),
    .dates_checked_o   (dates_checked),
    .dates_pending_o   (dates_pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d dates outstanding", cycle_count, dates_pending);
      $display("** epoch_seconds_to_calendar: FAILED **");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic longint unsigned jan1_day(input int unsigned yr);
    longint unsigned d = 0;
    for (int unsigned y = 1970; y < yr; y++) begin
      d += (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 366 : 365;
    end
    return d;
  endfunction

  function automatic logic [EpochBits-1:0] random_epoch();
    longint unsigned day_num;
    longint unsigned sod;
    longint unsigned total;
    case ($urandom_range(0, 3))
      0, 1: return $urandom;
      2: day_num = $urandom_range(0, 49710);
      default: begin
        day_num = jan1_day($urandom_range(1970, 2106));
        case ($urandom_range(0, 5))
          0:       day_num = (day_num == 0) ? 0 : day_num - 1;
          1:       day_num = day_num;
          2:       day_num += 58;
          3:       day_num += 59;
          4:       day_num += 60;
          default: day_num += 364 + $urandom_range(0, 1);
        endcase
      end
    endcase
    case ($urandom_range(0, 2))
      0:       sod = 0;
      1:       sod = 86399;
      default: sod = $urandom_range(0, 86399);
    endcase
    total = day_num * 86400 + sod;
    if (total > 64'hFFFF_FFFF) begin
      total = 64'hFFFF_FFFF - $urandom_range(0, 3);
    end
    return EpochBits'(total);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(input logic [EpochBits-1:0] secs);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < sender_idle_pct) @(negedge clk_i);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    requests_sent++;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    landmark_secs = '{
      32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd59, 32'd60, 32'd3599, 32'd3600,
      32'd86399, 32'd86400, 32'd2678399, 32'd2678400, 32'd31536000,
      32'd68169600, 32'd68256000, 32'd94694399, 32'd946684799, 32'd946684800,
      32'd951782400, 32'd951868800, 32'd978220800, 32'd1078058096,
      32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
      32'd4133980799
    };
    foreach (landmark_secs[i]) send_request(landmark_secs[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 77;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 77;
        end
        default: begin
          sender_idle_pct = 27;
          sink_stall_pct  = 27;
        end
      endcase
      repeat (RandomRequests / 4) send_request(random_epoch());
    end

    in_valid <= 1'b0;
    @(negedge clk_i);
    while (dates_pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("%0d requests sent: calendar landmarks, then random epochs under four idle/stall mixes",
             requests_sent);
    $display("%0d dates checked, %0d mismatches, %0d cycles", dates_checked, mismatch_count,
             cycle_count);
    if (mismatch_count == 0 && dates_pending == 0) begin
      $display("** epoch_seconds_to_calendar: PASSED **");
    end else begin
      $display("** epoch_seconds_to_calendar: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/es2cal_pkg.sv
hw/rtl/epoch_seconds_to_calendar.sv
hw/rtl/es2cal_chk.sv
verif/epoch_seconds_to_calendar_checker.sv
verif/epoch_seconds_to_calendar_tb.sv
